[sv/ssat_pkg.sv]
`timescale 1ns / 1ps
// Package for the sorted segment address table: table depth, derived widths,
// segment entry type, per-cell control struct and status codes. No dependencies.
package ssat_pkg;

	// Number of segment cells in the chain
	localparam int TABLE_DEPTH = 64;
	// Count width: must hold TABLE_DEPTH itself
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	// Hit gather tree: cells per first-level group
	localparam int GRP_SIZE = 8;
	localparam int GRP_NUM = (TABLE_DEPTH + GRP_SIZE - 1) / GRP_SIZE;

	// Beat widths
	localparam int IN_DATA_W = 128;
	localparam int OUT_DATA_W = 48;

	typedef logic [CNT_W-1:0] count_t;

	// One segment as held in a cell
	typedef struct packed {
		logic [31:0] start;
		logic [31:0] offset;
		logic [31:0] size;
	} entry_t;

	// Strobes sent from the sequencer to every cell
	typedef struct packed {
		logic cmp_en;
		logic ins_en;
	} cell_ctl_t;

	// Result status codes
	typedef enum logic [1:0] {
		STAT_OK       = 2'd0,
		STAT_NO_SEG   = 2'd1,
		STAT_TOO_LONG = 2'd2,
		STAT_FULL     = 2'd3
	} status_t;

	// Command codes carried on tuser
	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_LOOKUP = 1'b1;

endpackage

[sv/ssat_cell.sv]
`timescale 1ns / 1ps
// One cell of the sorted segment chain: holds one entry, compares it with the key
// and takes the new entry or its left neighbor's on insert. Uses ssat_pkg.
module ssat_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  ssat_pkg::cell_ctl_t ctl,
	input  logic [31:0]        key,
	input  logic               in_range,  // cell index is below the fill count
	input  ssat_pkg::entry_t   new_ent,
	input  ssat_pkg::entry_t   prev_ent,  // entry of the left neighbor
	input  logic               prev_le,   // left neighbor start <= key
	input  logic               next_le,   // right neighbor start <= key
	output ssat_pkg::entry_t   ent,
	output logic               le,
	output ssat_pkg::entry_t   hit_ent
);
	import ssat_pkg::*;

	entry_t ent_q;
	logic   le_q;

	// Compare flag: this cell holds a segment starting at or below the key
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			le_q <= 1'b0;
		end else if (ctl.cmp_en) begin
			le_q <= in_range && (ent_q.start <= key);
		end
	end

	// Insert: cells at or below the key keep, the first above takes the new
	// entry, the rest shift up from the left neighbor
	always_ff @(posedge clk) begin
		if (ctl.ins_en && !le_q) begin
			if (prev_le) begin
				ent_q <= new_ent;
			end else begin
				ent_q <= prev_ent;
			end
		end
	end

	assign ent = ent_q;
	assign le = le_q;
	// Last cell of the prefix of matches is the covering segment
	assign hit_ent = (le_q && !next_le) ? ent_q : '0;

endmodule

[sv/ssat_gather.sv]
`timescale 1ns / 1ps
// Two-level registered OR tree that collects the single hit entry of the chain.
// Uses ssat_pkg.
module ssat_gather (
	input  logic             clk,
	input  ssat_pkg::entry_t hit_ent [ssat_pkg::TABLE_DEPTH],
	output ssat_pkg::entry_t sel_ent
);
	import ssat_pkg::*;

	entry_t grp_s1 [GRP_NUM];
	entry_t sel_s2;
	entry_t grp_or [GRP_NUM];
	entry_t all_or;

	// First level: OR within each group of cells
	always_comb begin
		for (int g = 0; g < GRP_NUM; g++) begin
			grp_or[g] = '0;
			for (int k = 0; k < GRP_SIZE; k++) begin
				if (g * GRP_SIZE + k < TABLE_DEPTH) begin
					grp_or[g] = grp_or[g] | hit_ent[g * GRP_SIZE + k];
				end
			end
		end
	end

	// Second level: OR across groups
	always_comb begin
		all_or = '0;
		for (int g = 0; g < GRP_NUM; g++) begin
			all_or = all_or | grp_s1[g];
		end
	end

	always_ff @(posedge clk) begin
		grp_s1 <= grp_or;
		sel_s2 <= all_or;
	end

	assign sel_ent = sel_s2;

endmodule

[sv/sorted_segment_address_table.sv]
`timescale 1ns / 1ps
// Sorted segment address table: sequencer, chain of segment cells, hit gather
// tree and result register. Uses ssat_pkg, ssat_cell and ssat_gather.
//
// Usage:
//   The slave stream takes one command per beat. tuser selects insert (0) or
//   lookup (1); tdata carries address, file offset, segment size and request
//   length. Every input beat yields exactly one master beat holding status,
//   translated file position and the entry count after the command.
//   Inserts place the segment after all entries with a start at or below its
//   own, shifting the rest up one cell; a full table answers status 3.
//   Lookups pick the last segment starting at or below the address and
//   check that the requested bytes fit inside it.
//   Timing: one command at a time. A lookup also passes through the
//   registered OR tree that collects the hit cell before the offset add.
//   The result sits in an output register, so the next command is accepted
//   while the previous result waits; a command that finishes while the
//   register is still full holds until the receiver takes it.
//   Reset clears the entry count and the handshake state; the table is empty
//   and ready right after reset, with no clearing pass.
module sorted_segment_address_table (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [31:0] virt_address, [63:32] file_offset, [95:64] segment_bytes,
	// [127:96] request_bytes
	input  logic [ssat_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	// [0] cmd
	input  logic        s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [1:0] status, [34:2] file_position, [41:35] entry_count, [47:42] zero
	output logic [ssat_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
	import ssat_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CMP,
		S_INS,
		S_GATH1,
		S_GATH2,
		S_SEL,
		S_RESP
	} state_t;

	state_t      state_q;
	logic        cmd_q;
	logic [31:0] key_q;
	logic [31:0] req_q;
	entry_t      new_q;
	count_t      count_q;
	status_t     res_status_q;
	logic [32:0] res_pos_q;
	logic        m_valid_q;
	logic [OUT_DATA_W-1:0] m_data_q;

	cell_ctl_t   ctl;
	logic        full;
	entry_t      ent    [TABLE_DEPTH];
	entry_t      hit    [TABLE_DEPTH];
	logic        le     [TABLE_DEPTH];
	entry_t      sel_ent;
	logic [31:0] addr_delta;
	logic [32:0] need;
	logic [32:0] pos;
	logic        in_beat;
	logic        out_free;

	assign full = (count_q == CNT_W'(TABLE_DEPTH));
	assign ctl.cmp_en = (state_q == S_CMP);
	assign ctl.ins_en = (state_q == S_INS) && !full;

	// Cell chain
	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		logic   in_range;
		logic   prev_le;
		logic   next_le;
		entry_t prev_ent;

		assign in_range = (count_q > CNT_W'(i));
		if (i == 0) begin : g_first
			assign prev_le = 1'b1;
			assign prev_ent = new_q;
		end else begin : g_mid
			assign prev_le = le[i-1];
			assign prev_ent = ent[i-1];
		end
		if (i == TABLE_DEPTH - 1) begin : g_last
			assign next_le = 1'b0;
		end else begin : g_inner
			assign next_le = le[i+1];
		end

		ssat_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.key      (key_q),
			.in_range (in_range),
			.new_ent  (new_q),
			.prev_ent (prev_ent),
			.prev_le  (prev_le),
			.next_le  (next_le),
			.ent      (ent[i]),
			.le       (le[i]),
			.hit_ent  (hit[i])
		);
	end

	ssat_gather u_gather (
		.clk     (clk),
		.hit_ent (hit),
		.sel_ent (sel_ent)
	);

	// Lookup arithmetic on the gathered entry; key is at or above its start
	assign addr_delta = key_q - sel_ent.start;
	assign need = {1'b0, addr_delta} + {1'b0, req_q};
	assign pos = {1'b0, sel_ent.offset} + {1'b0, addr_delta};

	assign in_beat = s_axis_tvalid && s_axis_tready;
	assign out_free = !m_valid_q || m_axis_tready;

	// Command capture
	always_ff @(posedge clk) begin
		if (in_beat) begin
			cmd_q <= s_axis_tuser;
			key_q <= s_axis_tdata[31:0];
			new_q.start <= s_axis_tdata[31:0];
			new_q.offset <= s_axis_tdata[63:32];
			new_q.size <= s_axis_tdata[95:64];
			req_q <= s_axis_tdata[127:96];
		end
	end

	// Sequencer, entry count, result and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			res_status_q <= STAT_OK;
			res_pos_q <= '0;
			m_valid_q <= 1'b0;
			m_data_q <= '0;
		end else begin
			// Output valid: load on a finished command, drop once taken
			if (state_q == S_RESP && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_valid_q && m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_beat) begin
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					if (cmd_q == CMD_INSERT) begin
						state_q <= S_INS;
					end else begin
						state_q <= S_GATH1;
					end
				end
				S_INS: begin
					res_pos_q <= '0;
					if (full) begin
						res_status_q <= STAT_FULL;
					end else begin
						res_status_q <= STAT_OK;
						count_q <= count_q + 1'b1;
					end
					state_q <= S_RESP;
				end
				S_GATH1: begin
					state_q <= S_GATH2;
				end
				S_GATH2: begin
					state_q <= S_SEL;
				end
				S_SEL: begin
					// le of the first cell set means some start lies at or below the key
					if (!le[0]) begin
						res_status_q <= STAT_NO_SEG;
						res_pos_q <= '0;
					end else if (need > {1'b0, sel_ent.size}) begin
						res_status_q <= STAT_TOO_LONG;
						res_pos_q <= '0;
					end else begin
						res_status_q <= STAT_OK;
						res_pos_q <= pos;
					end
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (out_free) begin
						m_data_q <= {6'd0, 7'(count_q), res_pos_q, res_status_q};
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata = m_data_q;

endmodule
